// ----- sv/wav_header_scanner_assert.svh -----
// Assertion macros shared by the scanner checker.
`ifndef WAV_HEADER_SCANNER_ASSERT_SVH
`define WAV_HEADER_SCANNER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define WHS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("scanner assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define WHS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("scanner assertion failed");

`endif

// ----- sv/whs_pkg.sv -----
// Types, codes and constants of the WAV header scanner.
package whs_pkg;

    localparam int OFFSET_BITS_DEF = 32;

    // Field widths of the request and the result.
    localparam int BYTE_W   = 8;
    localparam int FSIZE_W  = 32;
    localparam int ST_W     = 3;
    localparam int BITS_W   = 16;
    localparam int OFS_W    = 32;
    localparam int CNT_W    = 32;
    localparam int RES_W    = ST_W + BITS_W + OFS_W + CNT_W;
    localparam int TDATA_W  = ((RES_W + 7) / 8) * 8;
    localparam int PAD_W    = TDATA_W - RES_W;

    // Header layout.
    localparam logic [31:0] MARK_FMT  = 32'h666D7420;
    localparam logic [31:0] MARK_DATA = 32'h64617461;
    localparam int MARK_LAST    = 3;
    localparam int FMT_MIN_LEN  = 24;
    localparam int TAG_OFS      = 8;
    localparam int DEPTH_OFS    = 22;
    localparam int DATA_HDR_LEN = 8;
    localparam logic [BITS_W-1:0] PCM_TAG = 16'd1;

    // Divider: the divisor is the bit depth divided by eight.
    localparam int DIVISOR_W = BITS_W - 3;
    localparam int STEP_W    = $clog2(CNT_W);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [ST_W-1:0] {
        ST_OK         = 3'd0,
        ST_NO_FMT     = 3'd1,
        ST_NOT_PCM    = 3'd2,
        ST_NO_DATA    = 3'd3,
        ST_BAD_DATA   = 3'd4,
        ST_ZERO_WIDTH = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        PH_SEEK_FMT,
        PH_SEEK_DATA,
        PH_DATA_FOUND
    } phase_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_HOLD
    } back_state_t;

    // One classified file, handed from the front to the back.
    typedef struct packed {
        status_t             status;
        logic [BITS_W-1:0]   bits;
        logic [OFS_W-1:0]    offset;
        logic [CNT_W-1:0]    length;
    } job_t;

    typedef struct packed {
        logic [CNT_W-1:0]    count;
        logic [OFS_W-1:0]    offset;
        logic [BITS_W-1:0]   bits;
        status_t             status;
    } res_t;

endpackage

// ----- sv/whs_front.sv -----
// Byte-level header parser: marker search, field capture and status decision.
module whs_front #(
    parameter int OFFSET_BITS = whs_pkg::OFFSET_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [whs_pkg::FSIZE_W-1:0]  file_size,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [whs_pkg::BYTE_W-1:0]   in_byte,
    input  logic                         in_first,
    output logic                         job_valid,
    input  logic                         job_ready,
    output whs_pkg::job_t                job
);

    // Compare width: holds any position plus a header offset, and file_size.
    localparam int CW = ((OFFSET_BITS > whs_pkg::FSIZE_W) ? OFFSET_BITS : whs_pkg::FSIZE_W) + 2;

    logic [31:0]                 window_reg, window_next;
    logic [OFFSET_BITS-1:0]      pos_reg, pos_next;
    whs_pkg::phase_t             phase_reg, phase_next, phase_base, phase_new;
    logic                        done_reg, done_next;
    logic [CW-1:0]               tag_pos_reg, tag_pos_next;
    logic [CW-1:0]               depth_pos_reg, depth_pos_next;
    logic [CW-1:0]               len_pos_reg, len_pos_next;
    logic [CW-1:0]               off_reg, off_next;
    logic [whs_pkg::BITS_W-1:0]  bits_reg, bits_next;
    logic [31:0]                 length_reg, length_next;

    logic                        accept, active, proc, pos_max;
    logic [31:0]                 win_base, win_new;
    logic [OFFSET_BITS-1:0]      pos_base;
    logic [CW-1:0]               p_ext, fs_ext;
    logic                        fmt_hit, fmt_short, tag_bad, depth_hit;
    logic                        data_hit, data_short, found, len_hit, eval, too_long;
    logic                        emit_main, end_hit;
    logic [whs_pkg::BITS_W-1:0]  bits_eff;
    logic [31:0]                 length_eff;

    assign in_ready = job_ready;
    assign accept   = in_valid & in_ready;

    // A first byte restarts the parse as if the state had been cleared.
    assign active     = in_first | ~done_reg;
    assign win_base   = in_first ? '0 : window_reg;
    assign pos_base   = in_first ? '0 : pos_reg;
    assign phase_base = in_first ? whs_pkg::PH_SEEK_FMT : phase_reg;

    assign p_ext   = CW'(pos_base);
    assign fs_ext  = CW'(file_size);
    assign pos_max = &pos_base;
    assign proc    = active & (p_ext < fs_ext) & ~pos_max;
    assign win_new = {win_base[23:0], in_byte};

    assign fmt_hit   = proc && (phase_base == whs_pkg::PH_SEEK_FMT) && (win_new == whs_pkg::MARK_FMT);
    assign fmt_short = fs_ext < p_ext + CW'(whs_pkg::FMT_MIN_LEN - whs_pkg::MARK_LAST);

    assign tag_bad   = proc && (phase_base != whs_pkg::PH_SEEK_FMT) && (p_ext == tag_pos_reg)
                       && ({win_new[7:0], win_new[15:8]} != whs_pkg::PCM_TAG);
    assign depth_hit = proc && (phase_base != whs_pkg::PH_SEEK_FMT) && (p_ext == depth_pos_reg);
    assign bits_eff  = depth_hit ? {win_new[7:0], win_new[15:8]} : bits_reg;

    assign data_hit   = proc && (phase_base == whs_pkg::PH_SEEK_DATA) && !tag_bad
                        && (win_new == whs_pkg::MARK_DATA);
    assign data_short = fs_ext < p_ext + CW'(whs_pkg::DATA_HDR_LEN - whs_pkg::MARK_LAST);
    assign found      = data_hit && !data_short;

    assign len_hit    = proc && (phase_base == whs_pkg::PH_DATA_FOUND) && !tag_bad
                        && (p_ext == len_pos_reg);
    assign length_eff = len_hit ? {win_new[7:0], win_new[15:8], win_new[23:16], win_new[31:24]}
                                : length_reg;
    assign eval       = proc && (phase_base == whs_pkg::PH_DATA_FOUND) && !tag_bad
                        && (p_ext >= len_pos_reg) && (p_ext >= depth_pos_reg);
    assign too_long   = (CW'(length_eff) + off_reg) > fs_ext;

    assign emit_main = (fmt_hit && fmt_short) || tag_bad || (data_hit && data_short) || eval;
    assign end_hit   = active && !emit_main && ((p_ext + CW'(1) >= fs_ext) || pos_max);

    // Next state of the parse phase.
    always_comb begin
        phase_new = phase_base;
        if (fmt_hit && !fmt_short) begin
            phase_new = whs_pkg::PH_SEEK_DATA;
        end else if (found) begin
            phase_new = whs_pkg::PH_DATA_FOUND;
        end
        phase_next = (accept && active) ? phase_new : phase_reg;
    end

    // Captured fields, position bookkeeping and the job handed to the queue.
    always_comb begin
        window_next    = window_reg;
        pos_next       = pos_reg;
        done_next      = done_reg;
        tag_pos_next   = tag_pos_reg;
        depth_pos_next = depth_pos_reg;
        len_pos_next   = len_pos_reg;
        off_next       = off_reg;
        bits_next      = bits_reg;
        length_next    = length_reg;
        job            = '0;
        job_valid      = 1'b0;

        if (fmt_hit) begin
            tag_pos_next   = p_ext + CW'(whs_pkg::TAG_OFS + 1 - whs_pkg::MARK_LAST);
            depth_pos_next = p_ext + CW'(whs_pkg::DEPTH_OFS + 1 - whs_pkg::MARK_LAST);
        end
        if (found) begin
            len_pos_next = p_ext + CW'(whs_pkg::DATA_HDR_LEN - 1 - whs_pkg::MARK_LAST);
            off_next     = p_ext + CW'(whs_pkg::DATA_HDR_LEN - whs_pkg::MARK_LAST);
        end
        bits_next   = bits_eff;
        length_next = length_eff;

        priority if (fmt_hit && fmt_short) begin
            job.status = whs_pkg::ST_NO_FMT;
        end else if (tag_bad) begin
            job.status = whs_pkg::ST_NOT_PCM;
        end else if (data_hit && data_short) begin
            job.status = whs_pkg::ST_NO_DATA;
        end else if (eval) begin
            job.bits   = bits_eff;
            job.offset = off_reg[whs_pkg::OFS_W-1:0];
            job.length = length_eff;
            if (too_long) begin
                job.status = whs_pkg::ST_BAD_DATA;
            end else if (bits_eff[whs_pkg::BITS_W-1:3] == '0) begin
                job.status = whs_pkg::ST_ZERO_WIDTH;
            end else begin
                job.status = whs_pkg::ST_OK;
            end
        end else if ((phase_new == whs_pkg::PH_SEEK_FMT) || (p_ext < depth_pos_next)) begin
            job.status = whs_pkg::ST_NO_FMT;
        end else begin
            job.status = whs_pkg::ST_NO_DATA;
        end

        if (accept && active) begin
            window_next = proc ? win_new : win_base;
            pos_next    = pos_max ? pos_base : pos_base + OFFSET_BITS'(1);
            done_next   = emit_main | end_hit;
            job_valid   = emit_main | end_hit;
        end
        if (!(accept && active)) begin
            tag_pos_next   = tag_pos_reg;
            depth_pos_next = depth_pos_reg;
            len_pos_next   = len_pos_reg;
            off_next       = off_reg;
            bits_next      = bits_reg;
            length_next    = length_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg <= '0;
            pos_reg    <= '0;
            phase_reg  <= whs_pkg::PH_SEEK_FMT;
            done_reg   <= 1'b0;
        end else begin
            window_reg <= window_next;
            pos_reg    <= pos_next;
            phase_reg  <= phase_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        tag_pos_reg   <= tag_pos_next;
        depth_pos_reg <= depth_pos_next;
        len_pos_reg   <= len_pos_next;
        off_reg       <= off_next;
        bits_reg      <= bits_next;
        length_reg    <= length_next;
    end

endmodule

// ----- sv/whs_queue.sv -----
// Short job queue between the parser and the divider back end.
module whs_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push_valid,
    output logic           push_ready,
    input  whs_pkg::job_t  push_job,
    output logic           pop_valid,
    input  logic           pop_ready,
    output whs_pkg::job_t  pop_job
);

    whs_pkg::job_t                entries_reg [whs_pkg::QUEUE_DEPTH];
    logic [whs_pkg::QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [whs_pkg::QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [whs_pkg::QCNT_W-1:0]   count_reg, count_next;
    logic                         do_push, do_pop;

    assign push_ready = count_reg != whs_pkg::QCNT_W'(whs_pkg::QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_job    = entries_reg[rd_ptr_reg];
    assign do_push    = push_valid & push_ready;
    assign do_pop     = pop_valid & pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == whs_pkg::QPTR_W'(whs_pkg::QUEUE_DEPTH - 1))
                          ? '0 : wr_ptr_reg + whs_pkg::QPTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == whs_pkg::QPTR_W'(whs_pkg::QUEUE_DEPTH - 1))
                          ? '0 : rd_ptr_reg + whs_pkg::QPTR_W'(1);
        end
        count_next = count_reg + whs_pkg::QCNT_W'(do_push) - whs_pkg::QCNT_W'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entries_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// ----- sv/whs_back.sv -----
// Result stage: radix-2 restoring divider for the sample count and output register.
module whs_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           job_valid,
    output logic           job_ready,
    input  whs_pkg::job_t  job,
    output logic           res_valid,
    input  logic           res_ready,
    output whs_pkg::res_t  res
);

    whs_pkg::back_state_t            state_reg, state_next;
    logic [whs_pkg::DIVISOR_W-1:0]   rem_reg, rem_next;
    logic [whs_pkg::DIVISOR_W-1:0]   divisor_reg, divisor_next;
    logic [whs_pkg::CNT_W-1:0]       quo_reg, quo_next;
    logic [whs_pkg::STEP_W-1:0]      step_reg, step_next;
    whs_pkg::status_t                status_reg, status_next;
    logic [whs_pkg::BITS_W-1:0]      bits_reg, bits_next;
    logic [whs_pkg::OFS_W-1:0]       offset_reg, offset_next;

    logic [whs_pkg::DIVISOR_W:0]     shifted, diff;
    logic                            take;

    assign take    = job_valid & job_ready;
    assign shifted = {rem_reg, quo_reg[whs_pkg::CNT_W-1]};
    assign diff    = shifted - {1'b0, divisor_reg};

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            whs_pkg::BK_IDLE: begin
                if (job_valid) begin
                    state_next = (job.status == whs_pkg::ST_OK) ? whs_pkg::BK_DIV
                                                                : whs_pkg::BK_HOLD;
                end
            end
            whs_pkg::BK_DIV: begin
                if (step_reg == '1) begin
                    state_next = whs_pkg::BK_HOLD;
                end
            end
            whs_pkg::BK_HOLD: begin
                if (res_ready) begin
                    state_next = whs_pkg::BK_IDLE;
                end
            end
            default: state_next = whs_pkg::BK_IDLE;
        endcase
    end

    // Handshake outputs.
    always_comb begin
        job_ready = 1'b0;
        res_valid = 1'b0;
        unique case (state_reg)
            whs_pkg::BK_IDLE: job_ready = 1'b1;
            whs_pkg::BK_DIV:  job_ready = 1'b0;
            whs_pkg::BK_HOLD: res_valid = 1'b1;
            default: begin
                job_ready = 1'b0;
                res_valid = 1'b0;
            end
        endcase
    end

    // Divider datapath; the quotient builds up in place of the shifted-out dividend.
    always_comb begin
        rem_next     = rem_reg;
        divisor_next = divisor_reg;
        quo_next     = quo_reg;
        step_next    = step_reg;
        status_next  = status_reg;
        bits_next    = bits_reg;
        offset_next  = offset_reg;
        if (take) begin
            rem_next     = '0;
            divisor_next = job.bits[whs_pkg::BITS_W-1:3];
            quo_next     = (job.status == whs_pkg::ST_OK) ? job.length : '0;
            step_next    = '0;
            status_next  = job.status;
            bits_next    = job.bits;
            offset_next  = job.offset;
        end else if (state_reg == whs_pkg::BK_DIV) begin
            if (!diff[whs_pkg::DIVISOR_W]) begin
                rem_next = diff[whs_pkg::DIVISOR_W-1:0];
                quo_next = {quo_reg[whs_pkg::CNT_W-2:0], 1'b1};
            end else begin
                rem_next = shifted[whs_pkg::DIVISOR_W-1:0];
                quo_next = {quo_reg[whs_pkg::CNT_W-2:0], 1'b0};
            end
            step_next = step_reg + whs_pkg::STEP_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= whs_pkg::BK_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg     <= rem_next;
        divisor_reg <= divisor_next;
        quo_reg     <= quo_next;
        step_reg    <= step_next;
        status_reg  <= status_next;
        bits_reg    <= bits_next;
        offset_reg  <= offset_next;
    end

    assign res.count  = quo_reg;
    assign res.offset = offset_reg;
    assign res.bits   = bits_reg;
    assign res.status = status_reg;

endmodule

// ----- sv/wav_header_scanner.sv -----
// Top level of the WAV header scanner: parser front, job queue and divider back end.
//
//   Channel  Direction  Handshake          Contents
//   s_       in         s_tvalid/s_tready  tdata: data_byte; tuser: first
//   cfg_     in         cfg_valid/ready    cfg_data: file_size
//   m_       out        m_tvalid/m_tready  tdata: status, sample_bits, data_offset, sample_count
//
// The parser takes one byte per cycle as long as the two-entry job queue has room.
// A result with status ok passes through the back end as load, divider steps and output;
// any other status goes from load straight to output; either waits there while m_tready is held low.
// Reset is synchronous and active low.
// s_tready drops only while the job queue is full; cfg_ready is always high.
module wav_header_scanner #(
    parameter int OFFSET_BITS = whs_pkg::OFFSET_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [whs_pkg::BYTE_W-1:0]    s_tdata,   // [7:0] data_byte
    input  logic                          s_tuser,   // [0] first
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [whs_pkg::FSIZE_W-1:0]   cfg_data,  // [31:0] file_size
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [2:0] status, [18:3] sample_bits, [50:19] data_offset, [82:51] sample_count
    output logic [whs_pkg::TDATA_W-1:0]   m_tdata
);

    logic [whs_pkg::FSIZE_W-1:0] file_size_reg, file_size_next;
    logic                        fq_valid, fq_ready, qb_valid, qb_ready;
    whs_pkg::job_t               fq_job, qb_job;
    whs_pkg::res_t               res;

    assign cfg_ready      = 1'b1;
    assign file_size_next = (cfg_valid && cfg_ready) ? cfg_data : file_size_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            file_size_reg <= '0;
        end else begin
            file_size_reg <= file_size_next;
        end
    end

    whs_front #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .file_size (file_size_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_byte   (s_tdata),
        .in_first  (s_tuser),
        .job_valid (fq_valid),
        .job_ready (fq_ready),
        .job       (fq_job)
    );

    whs_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_job   (fq_job),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_job    (qb_job)
    );

    whs_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_valid (qb_valid),
        .job_ready (qb_ready),
        .job       (qb_job),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res)
    );

    assign m_tdata = {{whs_pkg::PAD_W{1'b0}}, res};

endmodule

// ----- sv/whs_checker.sv -----
// Port-level checker for the WAV header scanner, bound to the top level.
`include "wav_header_scanner_assert.svh"

module whs_checker (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         m_tvalid,
    input  logic                         m_tready,
    input  logic [whs_pkg::TDATA_W-1:0]  m_tdata
);

    localparam int BITS_LSB = whs_pkg::ST_W;
    localparam int OFS_LSB  = BITS_LSB + whs_pkg::BITS_W;
    localparam int CNT_LSB  = OFS_LSB + whs_pkg::OFS_W;

    logic [whs_pkg::ST_W-1:0]    st;
    logic [whs_pkg::BITS_W-1:0]  bits;
    logic [whs_pkg::CNT_W-1:0]   cnt;
    logic                        early_fail;

    assign st   = m_tdata[whs_pkg::ST_W-1:0];
    assign bits = m_tdata[OFS_LSB-1:BITS_LSB];
    assign cnt  = m_tdata[whs_pkg::RES_W-1:CNT_LSB];
    assign early_fail = (st == whs_pkg::ST_NO_FMT) || (st == whs_pkg::ST_NOT_PCM)
                        || (st == whs_pkg::ST_NO_DATA);

    // A stalled result stays put.
    `WHS_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // Failures found before the data header carry no depth and no offset.
    `WHS_ASSERT_NOW(a_early_zero, m_tvalid && early_fail, m_tdata[whs_pkg::RES_W-1:BITS_LSB] == '0)

    // Only a successful parse has a sample count.
    `WHS_ASSERT_NOW(a_count_zero, m_tvalid && (st != whs_pkg::ST_OK), cnt == '0)

    // A successful parse implies a bit depth of at least one byte.
    `WHS_ASSERT_NOW(a_ok_depth, m_tvalid && (st == whs_pkg::ST_OK), bits[whs_pkg::BITS_W-1:3] != '0)

endmodule

bind wav_header_scanner whs_checker u_whs_checker (.*);

// ----- tb/tb_wav_header_scanner.sv -----
// Self-checking testbench for the WAV header scanner, with its own byte-level parse model.
module tb_wav_header_scanner;

    localparam logic [63:0] POS_LIMIT = (64'd1 << whs_pkg::OFFSET_BITS_DEF) - 1;
    localparam logic [31:0] RIFF_TAG = 32'h52494646;
    localparam logic [31:0] WAVE_TAG = 32'h57415645;
    localparam logic [31:0] LIST_TAG = 32'h4C495354;
    localparam int SETTLE_CYCLES = 40;
    localparam int TARGET_BYTES = 1050;

    typedef enum logic [1:0] {
        FEED_BYTE,
        FEED_CFG,
        FEED_QUIET
    } feed_kind_t;

    typedef struct {
        feed_kind_t  kind;
        logic [31:0] value;
        logic        first;
    } feed_t;

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [whs_pkg::BYTE_W-1:0]    s_tdata = '0;
    logic                          s_tuser = 1'b0;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [whs_pkg::FSIZE_W-1:0]   cfg_data = '0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [whs_pkg::TDATA_W-1:0]   m_tdata;

    wav_header_scanner uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #5 aclk = ~aclk;

    // Stimulus and expected results.
    feed_t           feed_q[$];
    logic [7:0]      file_bytes[$];
    whs_pkg::res_t   header_verdicts[$];

    // Parse model state.
    logic [63:0]      fsize_m = '0;
    logic [31:0]      win;
    logic [63:0]      scan_pos, fmt_at, data_at;
    whs_pkg::phase_t  scan_phase;
    logic [15:0]      tag, depth;
    logic [31:0]      dlen;
    logic             scan_done;

    int errors = 0;
    int active_bytes = 0;
    int bytes_queued = 0;
    int bytes_sent = 0;
    int files_started = 0;
    int config_writes = 0;
    int status_tally[8];
    bit tx_calm = 1'b0;
    bit rx_calm = 1'b0;

    task automatic report_error(string msg);
        $display("ERROR at %0t: %s", $time, msg);
        errors++;
    endtask

    function automatic void restart_scan();
        win = '0;
        scan_pos = '0;
        scan_phase = whs_pkg::PH_SEEK_FMT;
        fmt_at = '0;
        tag = '0;
        depth = '0;
        data_at = '0;
        dlen = '0;
        scan_done = 1'b0;
    endfunction

    // Advances the parse model by one accepted byte and queues the verdict it decides.
    function automatic void parse_wav_byte(logic [7:0] b, logic first);
        logic [63:0] p, f, d, off;
        whs_pkg::res_t r;
        logic hit;
        if (first)
            restart_scan();
        if (scan_done)
            return;
        active_bytes++;
        hit = 1'b0;
        r = '0;
        p = scan_pos;
        f = fmt_at;
        if (p < fsize_m && p < POS_LIMIT) begin
            win = {win[23:0], b};
            if (scan_phase == whs_pkg::PH_SEEK_FMT) begin
                if (win == whs_pkg::MARK_FMT) begin
                    fmt_at = p - 3;
                    if (fsize_m - fmt_at < whs_pkg::FMT_MIN_LEN) begin
                        r.status = whs_pkg::ST_NO_FMT;
                        hit = 1'b1;
                    end else begin
                        scan_phase = whs_pkg::PH_SEEK_DATA;
                    end
                end
            end else begin
                if (p == f + whs_pkg::TAG_OFS + 1) begin
                    tag = {win[7:0], win[15:8]};
                    if (tag != whs_pkg::PCM_TAG) begin
                        r.status = whs_pkg::ST_NOT_PCM;
                        hit = 1'b1;
                    end
                end
                if (!hit && p == f + whs_pkg::DEPTH_OFS + 1)
                    depth = {win[7:0], win[15:8]};
                if (!hit && scan_phase == whs_pkg::PH_SEEK_DATA && win == whs_pkg::MARK_DATA) begin
                    data_at = p - 3;
                    if (fsize_m - data_at < whs_pkg::DATA_HDR_LEN) begin
                        r.status = whs_pkg::ST_NO_DATA;
                        hit = 1'b1;
                    end else begin
                        scan_phase = whs_pkg::PH_DATA_FOUND;
                    end
                end
                d = data_at;
                if (!hit && scan_phase == whs_pkg::PH_DATA_FOUND && p == d + 7)
                    dlen = {win[7:0], win[15:8], win[23:16], win[31:24]};
                if (!hit && scan_phase == whs_pkg::PH_DATA_FOUND && p >= d + 7
                    && p >= f + 23) begin
                    off = d + whs_pkg::DATA_HDR_LEN;
                    hit = 1'b1;
                    r.bits = depth;
                    r.offset = off[31:0];
                    if ({32'd0, dlen} + off > fsize_m)
                        r.status = whs_pkg::ST_BAD_DATA;
                    else if (depth < 8)
                        r.status = whs_pkg::ST_ZERO_WIDTH;
                    else begin
                        r.status = whs_pkg::ST_OK;
                        r.count = dlen / (depth >> 3);
                    end
                end
            end
        end
        // End of file: the fmt position used here is the one from before this byte.
        if (!hit && (p + 1 >= fsize_m || p >= POS_LIMIT)) begin
            r.status = (scan_phase == whs_pkg::PH_SEEK_FMT || p < f + 23)
                       ? whs_pkg::ST_NO_FMT : whs_pkg::ST_NO_DATA;
            hit = 1'b1;
        end
        if (scan_pos < POS_LIMIT)
            scan_pos++;
        if (hit) begin
            scan_done = 1'b1;
            header_verdicts.push_back(r);
        end
    endfunction

    // File building helpers.
    function automatic void put_le(logic [31:0] v, int n);
        for (int i = 0; i < n; i++)
            file_bytes.push_back(v[8*i +: 8]);
    endfunction

    function automatic void put_mark(logic [31:0] m);
        for (int i = 3; i >= 0; i--)
            file_bytes.push_back(m[8*i +: 8]);
    endfunction

    function automatic void put_rand(int n);
        for (int i = 0; i < n; i++)
            file_bytes.push_back(8'($urandom));
    endfunction

    // Moves the leading bytes of the file under construction to the request queue.
    function automatic void flush_file(logic lead_first, int upto);
        for (int i = 0; i < upto; i++) begin
            feed_q.push_back('{kind: FEED_BYTE, value: {24'd0, file_bytes.pop_front()},
                               first: lead_first && (i == 0)});
            bytes_queued++;
        end
    endfunction

    function automatic void add_cfg(logic [31:0] v);
        feed_q.push_back('{kind: FEED_CFG, value: v, first: 1'b0});
    endfunction

    function automatic logic [31:0] pick_len(logic [31:0] fsize, int d);
        logic [31:0] room;
        room = fsize - d - whs_pkg::DATA_HDR_LEN;
        case ($urandom_range(0, 6))
            0: return $urandom_range(0, 64);
            1: return $urandom;
            2: return room;
            3: return room + 1;
            4: return room - 1;
            5: return 32'hFFFF_FFFF;
            default: return $urandom_range(0, 600);
        endcase
    endfunction

    function automatic void build_file(logic [31:0] fsize);
        int shape, f, d;
        logic [15:0] depth_f;
        shape = $urandom_range(0, 19);
        if (shape == 0) begin
            put_rand($urandom_range(1, 24));
            return;
        end
        if ($urandom_range(0, 3) != 0) begin
            put_mark(RIFF_TAG);
            put_rand(4);
            put_mark(WAVE_TAG);
        end else begin
            put_rand($urandom_range(0, 5));
        end
        if (shape != 1) begin
            f = file_bytes.size();
            put_mark(whs_pkg::MARK_FMT);
            put_le(16, 4);
            put_le(($urandom_range(0, 7) == 0) ? $urandom : 1, 2);
            if (shape == 2) begin
                // A data marker hidden in the rate fields of the fmt section.
                put_rand(2);
                put_mark(whs_pkg::MARK_DATA);
                put_le(pick_len(fsize, f + 12), 4);
                put_rand(2);
            end else begin
                put_rand(12);
            end
            case ($urandom_range(0, 11))
                0: depth_f = 8;
                1: depth_f = 24;
                2: depth_f = 32;
                3: depth_f = 0;
                4: depth_f = 7;
                5: depth_f = 4;
                6: depth_f = 12;
                7: depth_f = 16'hFFFF;
                8: depth_f = 16'($urandom);
                default: depth_f = 16;
            endcase
            put_le(depth_f, 2);
        end
        if (shape == 3) begin
            put_mark(LIST_TAG);
            put_rand($urandom_range(0, 12));
        end
        if (shape != 4) begin
            d = file_bytes.size();
            put_mark(whs_pkg::MARK_DATA);
            put_le(pick_len(fsize, d), 4);
        end
        put_rand($urandom_range(0, 4));
    endfunction

    function automatic void add_phase();
        logic [31:0] fsize;
        int nfiles;
        case ($urandom_range(0, 9))
            0: fsize = 0;
            1: fsize = $urandom_range(1, 40);
            2: fsize = 32'hFFFF_FFFF;
            3: fsize = $urandom;
            4: fsize = 32'hFFFF_FFFE;
            default: fsize = $urandom_range(30, 400);
        endcase
        add_cfg(fsize);
        // Tail of a file that was cut by the setting change.
        flush_file(1'b0, file_bytes.size());
        nfiles = (fsize < 8) ? 2 : $urandom_range(3, 8);
        for (int i = 0; i < nfiles; i++) begin
            if (bytes_queued >= TARGET_BYTES)
                break;
            build_file(fsize);
            if (i == nfiles - 1 && $urandom_range(0, 2) == 0) begin
                flush_file(1'b1, $urandom_range(1, file_bytes.size()));
            end else if ($urandom_range(0, 9) == 0) begin
                flush_file(1'b1, $urandom_range(1, file_bytes.size()));
                file_bytes.delete();
            end else begin
                flush_file($urandom_range(0, 19) != 0, file_bytes.size());
            end
            if ($urandom_range(0, 11) == 0)
                feed_q.push_back('{kind: FEED_QUIET, value: '0, first: 1'b0});
        end
    endfunction

    // Sender: one request at a time from the queue; setting writes and pauses wait for
    // every outstanding result and then a settling time.
    int tx_gap = 0;
    int settle = 0;

    always @(posedge aclk) begin : driver
        feed_t ent;
        logic v_next, c_next;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            cfg_valid <= 1'b0;
            tx_gap = 0;
            settle = 0;
        end else begin
            v_next = s_tvalid;
            c_next = cfg_valid;
            if (s_tvalid && s_tready) begin
                parse_wav_byte(s_tdata, s_tuser);
                bytes_sent++;
                if (s_tuser)
                    files_started++;
                if ($urandom_range(0, 199) == 0)
                    tx_calm = !tx_calm;
                tx_gap = tx_calm ? 0 : $urandom_range(0, 3);
                v_next = 1'b0;
            end
            if (cfg_valid && cfg_ready) begin
                fsize_m = {32'd0, cfg_data};
                config_writes++;
                c_next = 1'b0;
            end
            if (!v_next && !c_next) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                end else if (feed_q.size() != 0) begin
                    ent = feed_q[0];
                    if (ent.kind == FEED_BYTE) begin
                        void'(feed_q.pop_front());
                        s_tdata <= ent.value[7:0];
                        s_tuser <= ent.first;
                        v_next = 1'b1;
                    end else if (header_verdicts.size() != 0) begin
                        settle = 0;
                    end else if (settle < SETTLE_CYCLES) begin
                        settle++;
                    end else begin
                        settle = 0;
                        void'(feed_q.pop_front());
                        if (ent.kind == FEED_CFG) begin
                            cfg_data <= ent.value;
                            c_next = 1'b1;
                        end
                    end
                end
            end
            s_tvalid <= v_next;
            cfg_valid <= c_next;
        end
    end

    // Receiver: random stalls per result, calm stretches, and two long hold-offs.
    int rx_wait = 0;
    int hold_left = 0;
    int taken = 0;

    always @(posedge aclk) begin : receiver
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_wait = 0;
            hold_left = 0;
            taken = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                taken++;
                if ($urandom_range(0, 14) == 0)
                    rx_calm = !rx_calm;
                rx_wait = rx_calm ? 0 : $urandom_range(0, 3);
                if (taken == 15 || taken == 60)
                    hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (rx_wait > 0) begin
                rx_wait--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin : monitor
        whs_pkg::res_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = whs_pkg::res_t'(m_tdata[whs_pkg::RES_W-1:0]);
            if (header_verdicts.size() == 0) begin
                report_error($sformatf("result with none expected, status %0d", got.status));
            end else begin
                want = header_verdicts.pop_front();
                status_tally[want.status]++;
                if (got.status != want.status)
                    report_error($sformatf("status: expected %0d, got %0d",
                                           want.status, got.status));
                if (got.bits != want.bits)
                    report_error($sformatf("sample_bits: expected %0d, got %0d",
                                           want.bits, got.bits));
                if (got.offset != want.offset)
                    report_error($sformatf("data_offset: expected 0x%h, got 0x%h",
                                           want.offset, got.offset));
                if (got.count != want.count)
                    report_error($sformatf("sample_count: expected %0d, got %0d",
                                           want.count, got.count));
            end
        end
    end

    initial begin
        #4_000_000;
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        restart_scan();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Empty file size: the very first byte decides, the next is ignored.
        add_cfg(0);
        file_bytes = '{8'h00, 8'hFF};
        flush_file(1'b1, 1);
        flush_file(1'b0, 1);
        // A fmt marker with too few bytes left in the file.
        add_cfg(4);
        put_mark(whs_pkg::MARK_FMT);
        flush_file(1'b1, 4);
        // A format tag that is not PCM.
        add_cfg(100);
        put_mark(whs_pkg::MARK_FMT);
        put_le(16, 4);
        put_le(32'hFF00, 2);
        flush_file(1'b1, 10);
        // The file size shrinks in the middle of a file.
        add_cfg(32'hFFFF_FFFF);
        put_mark(whs_pkg::MARK_FMT);
        put_rand(3);
        flush_file(1'b1, 7);
        add_cfg(5);
        put_rand(1);
        flush_file(1'b0, 1);

        while (bytes_queued < TARGET_BYTES) begin
            if (feed_q.size() < 40)
                add_phase();
            else
                @(posedge aclk);
        end
        while (feed_q.size() != 0 || s_tvalid || cfg_valid)
            @(posedge aclk);
        while (header_verdicts.size() != 0)
            @(posedge aclk);
        repeat (50) @(posedge aclk);

        $display("Sent %0d bytes (%0d parsed) in %0d files under %0d file-size settings.",
                 bytes_sent, active_bytes, files_started, config_writes);
        $display("Results: ok %0d, no fmt %0d, not PCM %0d, no data %0d, past end %0d, narrow %0d",
                 status_tally[whs_pkg::ST_OK], status_tally[whs_pkg::ST_NO_FMT],
                 status_tally[whs_pkg::ST_NOT_PCM], status_tally[whs_pkg::ST_NO_DATA],
                 status_tally[whs_pkg::ST_BAD_DATA], status_tally[whs_pkg::ST_ZERO_WIDTH]);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
